### sv/lcr_pkg.sv
// Types and constants used by the load cell reader top level.
`default_nettype none

package lcr_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_PLAIN = 2'd0;
    localparam logic [1:0] FUNC_WEIGH = 2'd1;
    localparam logic [1:0] FUNC_TARE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_WAIT_LIMIT  = 2'd0;
    localparam logic [1:0] REG_ZERO_MARGIN = 2'd1;
    localparam logic [1:0] REG_GAP_DOUBLED = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int WAIT_W = 24;
    localparam int MARGIN_W = 16;
    localparam int GAP_W = 16;
    localparam int WEIGHT_W = 20;

    localparam logic [WAIT_W-1:0]   WAIT_LIMIT_RST  = 24'd1000000;
    localparam logic [MARGIN_W-1:0] ZERO_MARGIN_RST = 16'd200;
    localparam logic [GAP_W-1:0]    GAP_DOUBLED_RST = 16'd841;

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 20'sh7FFFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 20'sh80000;
    localparam int WEIGHT_POS_LIM = 524287;
    localparam int WEIGHT_NEG_LIM = 524288;

    // Serial protocol phase
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_WAIT   = 5'b00010,
        PH_HIGH   = 5'b00100,
        PH_SAMPLE = 5'b01000,
        PH_PULSE  = 5'b10000
    } phase_t;

    // Request/divide sequencer
    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_DIV  = 3'b010,
        C_FIN  = 3'b100
    } ctl_t;

endpackage

`default_nettype wire

### sv/lcr_if.sv
// Request and result channel interfaces of the load cell reader.
`default_nettype none

interface lcr_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       dout_level;

    modport source (output valid, output func, output dout_level, input ready);
    modport sink (input valid, input func, input dout_level, output ready);
endinterface

interface lcr_res_if #(
    parameter int DATA_BITS = 24
);
    logic                 valid;
    logic                 ready;
    logic                 sck_level;
    logic                 busy_res;
    logic                 done_res;
    logic                 timed_out;
    logic [DATA_BITS-1:0] raw_reading;
    logic signed [19:0]   weight;

    modport source (
        output valid, output sck_level, output busy_res, output done_res,
        output timed_out, output raw_reading, output weight, input ready
    );
    modport sink (
        input valid, input sck_level, input busy_res, input done_res,
        input timed_out, input raw_reading, input weight, output ready
    );
endinterface

`default_nettype wire

### sv/load_cell_adc_reader_tare_scale_unit.sv
// Top level of the load cell converter reader with tare and scaling.
`default_nettype none

// Load cell reader. Each request on req is one half-bit tick carrying the sampled
// data-out level and an optional start command (weigh or tare); each request
// produces exactly one result on res with the serial clock level to drive, the
// busy/done flags and, on completion, the raw reading and the tared weight.
// A start holds the serial clock low until data-out drops (or the wait limit
// expires, giving a raw reading of zero), then clocks DATA_BITS bits sampled
// after each falling edge, gives one extra pulse and inverts the top bit.
// A tare start stores the raw reading; a weigh start yields
// trunc((raw - tare) * 2 / gap_doubled), saturated to 20 bits, or zero when the
// tare is below the margin or the reading is not above tare minus margin.
// An ordinary tick's result is registered in the cycle after the request is taken.
// The completing tick of a weigh that passes the zero checks waits for a
// restoring divider built around one 17-bit subtract/compare, which produces
// one quotient bit per cycle over DATA_BITS + 2 dividend bits; then the C_FIN
// state applies sign and saturation before the result is registered.
// No further request is taken while the divider runs. Configuration registers
// (0 wait_limit, 1 zero_margin, 2 gap_doubled) are written through cfg_we /
// cfg_index / cfg_data and must be written only while the block is idle.
module load_cell_adc_reader_tare_scale_unit #(
    parameter int DATA_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lcr_req_if.sink                             req,
    lcr_res_if.source                           res,
    input  wire logic                           cfg_we,
    input  wire logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lcr_pkg::*;

    localparam int BCW = $clog2(DATA_BITS + 1);
    localparam int CW  = (DATA_BITS > MARGIN_W) ? DATA_BITS : MARGIN_W;
    localparam int QW  = DATA_BITS + 2;
    localparam int QCW = $clog2(QW + 1);
    localparam int SW  = (QW > WEIGHT_W + 1) ? QW : WEIGHT_W + 1;

    // Configuration registers
    logic [WAIT_W-1:0]   wait_limit_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [GAP_W-1:0]    gap_reg;

    // Protocol state
    phase_t               phase_reg, phase_next;
    logic [BCW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [WAIT_W-1:0]    wait_cnt_reg, wait_cnt_next;
    logic [DATA_BITS-1:0] tare_reg, tare_next;
    logic                 tare_mode_reg, tare_mode_next;

    // Sequencer and divider
    ctl_t               ctl_reg, ctl_next;
    logic [QW-1:0]      mag_reg, mag_next;
    logic [GAP_W-1:0]   rem_reg, rem_next;
    logic [QCW-1:0]     qcnt_reg, qcnt_next;
    logic               neg_reg, neg_next;

    // Result register
    logic                        out_valid_reg, out_valid_next;
    logic                        sck_reg, sck_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        tmo_reg, tmo_next;
    logic [DATA_BITS-1:0]        raw_reg, raw_next;
    logic signed [WEIGHT_W-1:0]  weight_reg, weight_next;

    // Tick decode
    logic                 accept;
    logic                 tick_sck;
    logic                 finish;
    logic                 tick_tmo;
    logic [DATA_BITS-1:0] raw_val;
    logic [WAIT_W-1:0]    wait_inc;
    logic [BCW-1:0]       bit_inc;

    // Weigh evaluation
    logic                 tare_ok;
    logic [CW-1:0]        thresh;
    logic                 above;
    logic                 need_div;
    logic [DATA_BITS:0]   diff;
    logic [DATA_BITS:0]   diff_abs;

    // Divider datapath
    logic [GAP_W-1:0]     divisor;
    logic [GAP_W:0]       trial;
    logic                 trial_ge;
    logic [GAP_W:0]       trial_sub;
    logic [SW-1:0]        mag_ext;

    assign accept = req.valid && req.ready;
    // Take a request only with the divider idle and room in the result register.
    assign req.ready = (ctl_reg == C_IDLE) && (!out_valid_reg || res.ready);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_limit_reg <= WAIT_LIMIT_RST;
            margin_reg     <= ZERO_MARGIN_RST;
            gap_reg        <= GAP_DOUBLED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WAIT_LIMIT:  wait_limit_reg <= cfg_data[WAIT_W-1:0];
                REG_ZERO_MARGIN: margin_reg <= cfg_data[MARGIN_W-1:0];
                REG_GAP_DOUBLED: gap_reg <= cfg_data[GAP_W-1:0];
                default:         ;
            endcase
        end
    end

    // Per-tick protocol step
    always_comb
    begin
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        wait_cnt_next  = wait_cnt_reg;
        tare_next      = tare_reg;
        tare_mode_next = tare_mode_reg;
        tick_sck       = 1'b0;
        finish         = 1'b0;
        tick_tmo       = 1'b0;
        raw_val        = '0;
        wait_inc       = wait_cnt_reg + WAIT_W'(1);
        bit_inc        = bit_cnt_reg + BCW'(1);

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.func == FUNC_WEIGH || req.func == FUNC_TARE)
                begin
                    tare_mode_next = (req.func == FUNC_TARE);
                    wait_cnt_next  = '0;
                    bit_cnt_next   = '0;
                    shift_next     = '0;
                    phase_next     = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (!req.dout_level)
                begin
                    bit_cnt_next = '0;
                    shift_next   = '0;
                    tick_sck     = 1'b1;
                    phase_next   = PH_HIGH;
                end
                else
                begin
                    wait_cnt_next = wait_inc;
                    // A zero count after wrap or a zero limit also expires.
                    if (wait_inc >= wait_limit_reg || wait_inc == '0)
                    begin
                        finish   = 1'b1;
                        tick_tmo = 1'b1;
                    end
                end
            end
            PH_HIGH:
            begin
                phase_next = PH_SAMPLE;
            end
            PH_SAMPLE:
            begin
                shift_next   = {shift_reg[DATA_BITS-2:0], req.dout_level};
                bit_cnt_next = bit_inc;
                tick_sck     = 1'b1;
                phase_next   = (bit_inc >= BCW'(DATA_BITS)) ? PH_PULSE : PH_HIGH;
            end
            PH_PULSE:
            begin
                finish  = 1'b1;
                raw_val = shift_reg ^ {1'b1, {(DATA_BITS-1){1'b0}}};
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (finish)
        begin
            phase_next = PH_IDLE;
            if (tare_mode_reg)
            begin
                tare_next = raw_val;
            end
        end
    end

    // Zero checks and signed difference for a weigh completion
    always_comb
    begin
        tare_ok  = CW'(tare_reg) >= CW'(margin_reg);
        thresh   = CW'(tare_reg) - CW'(margin_reg);
        above    = CW'(raw_val) > thresh;
        need_div = finish && !tare_mode_reg && tare_ok && above;
        diff     = {1'b0, raw_val} - {1'b0, tare_reg};
        diff_abs = diff[DATA_BITS] ? (~diff + (DATA_BITS+1)'(1)) : diff;
    end

    // Restoring divide step: one quotient bit per cycle
    always_comb
    begin
        divisor   = (gap_reg == '0) ? GAP_W'(1) : gap_reg;
        trial     = {rem_reg, mag_reg[QW-1]};
        trial_ge  = trial >= {1'b0, divisor};
        trial_sub = trial - {1'b0, divisor};
        mag_ext   = SW'(mag_reg);
    end

    // Sequencer, divider and result register
    always_comb
    begin
        ctl_next       = ctl_reg;
        mag_next       = mag_reg;
        rem_next       = rem_reg;
        qcnt_next      = qcnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !res.ready;
        sck_next       = sck_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        tmo_next       = tmo_reg;
        raw_next       = raw_reg;
        weight_next    = weight_reg;

        unique case (ctl_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    sck_next    = tick_sck;
                    busy_next   = (phase_next != PH_IDLE);
                    done_next   = finish;
                    tmo_next    = tick_tmo;
                    raw_next    = raw_val;
                    weight_next = '0;
                    if (need_div)
                    begin
                        // Hold the result back until the quotient is ready.
                        mag_next  = {diff_abs, 1'b0};
                        neg_next  = diff[DATA_BITS];
                        rem_next  = '0;
                        qcnt_next = QCW'(QW);
                        ctl_next  = C_DIV;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            C_DIV:
            begin
                rem_next  = trial_ge ? trial_sub[GAP_W-1:0] : trial[GAP_W-1:0];
                mag_next  = {mag_reg[QW-2:0], trial_ge};
                qcnt_next = qcnt_reg - QCW'(1);
                if (qcnt_reg == QCW'(1))
                begin
                    ctl_next = C_FIN;
                end
            end
            C_FIN:
            begin
                // Apply sign and saturate into the weight range.
                if (neg_reg)
                begin
                    if (mag_ext > SW'(WEIGHT_NEG_LIM))
                        weight_next = WEIGHT_MIN;
                    else
                        weight_next = -$signed(mag_ext[WEIGHT_W-1:0]);
                end
                else
                begin
                    if (mag_ext > SW'(WEIGHT_POS_LIM))
                        weight_next = WEIGHT_MAX;
                    else
                        weight_next = $signed(mag_ext[WEIGHT_W-1:0]);
                end
                out_valid_next = 1'b1;
                ctl_next       = C_IDLE;
            end
            default:
            begin
                ctl_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            wait_cnt_reg  <= '0;
            tare_reg      <= '0;
            tare_mode_reg <= 1'b0;
            ctl_reg       <= C_IDLE;
            qcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                bit_cnt_reg   <= bit_cnt_next;
                shift_reg     <= shift_next;
                wait_cnt_reg  <= wait_cnt_next;
                tare_reg      <= tare_next;
                tare_mode_reg <= tare_mode_next;
            end
            ctl_reg       <= ctl_next;
            qcnt_reg      <= qcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        sck_reg    <= sck_next;
        busy_reg   <= busy_next;
        done_reg   <= done_next;
        tmo_reg    <= tmo_next;
        raw_reg    <= raw_next;
        weight_reg <= weight_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.sck_level   = sck_reg;
    assign res.busy_res    = busy_reg;
    assign res.done_res    = done_reg;
    assign res.timed_out   = tmo_reg;
    assign res.raw_reading = raw_reg;
    assign res.weight      = weight_reg;

    // No request may enter while the divider owns the result register.
    a_no_req_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg != C_IDLE |-> !req.ready)
        else $error("request taken while divider busy");

    // The sign/saturate cycle always delivers a result.
    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg == C_FIN |=> res.valid)
        else $error("divide result not delivered");

    // A timeout completes the reading with a zero raw value.
    a_timeout_raw: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.timed_out |-> res.done_res && res.raw_reading == '0)
        else $error("timeout result malformed");

    // A completed reading leaves the block idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.done_res |-> !res.busy_res)
        else $error("busy reported on completion");

endmodule

`default_nettype wire
